[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every clock edge outside reset
`define PIHD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// check prop on every clock edge, reset included
`define PIHD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

[design/pihd_pkg.sv]
// ---------------------------------------------------------------------------
// PI heater duty controller package
// Field types, register indexes, reset values and fixed-point constants.
// ---------------------------------------------------------------------------
`default_nettype none

package pihd_pkg;

   typedef logic signed [15:0] temp_type;
   typedef logic        [15:0] gain_type;
   typedef logic        [15:0] period_type;
   typedef logic        [6:0]  duty_type;
   typedef logic        [15:0] compare_type;
   typedef logic        [1:0]  csr_index_type;
   typedef logic        [15:0] csr_data_type;

   localparam csr_index_type CSR_PROP_GAIN  = 2'd0;
   localparam csr_index_type CSR_INTEG_GAIN = 2'd1;
   localparam csr_index_type CSR_PWM_PERIOD = 2'd2;

   localparam gain_type   RESET_PROP_GAIN  = 16'd3840;
   localparam gain_type   RESET_INTEG_GAIN = 16'd92;
   localparam period_type RESET_PWM_PERIOD = 16'd50000;

   localparam int ERR_W    = 17;
   localparam int SUM_W    = 32;
   localparam int PPROD_W  = 34;
   localparam int IPROD_W  = 49;
   localparam int RAW_W    = 50;
   localparam int FRAC_BITS = 16;
   localparam int DUTY_MAX    = 100;
   localparam int DUTY_MIN_ON = 50;
   localparam int SCALED_W = 23;

   // ceil(2^32 / 100): exact quotient for dividends below 2^30
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 26;
   localparam logic [RECIP_W-1:0] RECIP_100 = 26'd42949673;
   localparam int QPROD_W = SCALED_W + RECIP_W;

endpackage

`default_nettype wire

[design/pihd_if.sv]
// ---------------------------------------------------------------------------
// PI heater duty controller channels
// Request, response and register-write handshake interfaces.
// ---------------------------------------------------------------------------
`default_nettype none

interface pihd_req_if;
   import pihd_pkg::*;
   logic     valid;
   logic     ready;
   temp_type target_temp;
   temp_type measured_temp;
   modport source (output valid, output target_temp, output measured_temp, input ready);
   modport sink   (input valid, input target_temp, input measured_temp, output ready);
endinterface

interface pihd_rsp_if;
   import pihd_pkg::*;
   logic        valid;
   logic        ready;
   duty_type    duty_percent;
   compare_type compare_value;
   modport source (output valid, output duty_percent, output compare_value, input ready);
   modport sink   (input valid, input duty_percent, input compare_value, output ready);
endinterface

interface pihd_csr_if;
   import pihd_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/pi_heater_duty_controller_top.sv]
// ---------------------------------------------------------------------------
// PI heater duty controller
// Usage:
//   req carries one word per sample: target and measured temperature, both
//   signed Q8.8. rsp returns one word per sample: duty percent (0 or 50..100)
//   and the PWM compare count duty * period / 100.
//   csr writes prop_gain (index 0), integ_gain (1) and pwm_period (2); it is
//   always ready, other indexes are dropped. Write only while idle.
// Path: each accepted word passes the error, product, clamp, scale and output
//   registers in turn before it shows on rsp.
// Throughput: one word per cycle unless rsp stalls, set by the five stages
//   (integral update, gain multiplies, sum and clamp, period multiply,
//   reciprocal divide by 100); the integral is updated in the accept cycle.
// Stall: when rsp is held off, each stage holds and the empty stages ahead
//   still fill, so up to five words are taken before req drops ready.
// Reset: synchronous; clears the integral, all stage valids and loads the
//   default gains and period.
// ---------------------------------------------------------------------------
`default_nettype none

module pi_heater_duty_controller_top (
   input wire logic clock,
   input wire logic reset,
   pihd_req_if.sink   req,
   pihd_rsp_if.source rsp,
   pihd_csr_if.sink   csr
);
   import pihd_pkg::*;

   gain_type   prop_gain_ff;
   gain_type   integ_gain_ff;
   period_type pwm_period_ff;

   logic signed [SUM_W-1:0] error_sum_ff;
   logic signed [SUM_W-1:0] error_sum_in;
   logic signed [ERR_W-1:0] err_in;
   logic signed [SUM_W:0]   sum_wide;

   logic                      v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic                      adv1, adv2, adv3, adv4, adv5;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [PPROD_W-1:0] pprod_ff, pprod_in;
   logic signed [IPROD_W-1:0] iprod_ff, iprod_in;
   logic signed [RAW_W-1:0]   raw_sum;
   duty_type                  duty3_ff, duty3_in;
   duty_type                  duty4_ff;
   logic [SCALED_W-1:0]       scaled_ff, scaled_in;
   logic [QPROD_W-1:0]        qprod;
   duty_type                  duty_out_ff;
   compare_type               compare_out_ff;

   localparam logic signed [RAW_W-1:0] RAW_FULL = RAW_W'(DUTY_MAX * (2 ** FRAC_BITS));

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= RESET_PROP_GAIN;
         integ_gain_ff <= RESET_INTEG_GAIN;
         pwm_period_ff <= RESET_PWM_PERIOD;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_PROP_GAIN:  prop_gain_ff  <= csr.data;
            CSR_INTEG_GAIN: integ_gain_ff <= csr.data;
            CSR_PWM_PERIOD: pwm_period_ff <= csr.data;
            default: ;
         endcase
      end
   end

   assign adv5 = !rsp_valid_ff || rsp.ready;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req.ready = adv1;

   // error and saturating integral
   always_comb begin
      err_in   = ERR_W'(req.target_temp) - ERR_W'(req.measured_temp);
      sum_wide = $signed({error_sum_ff[SUM_W-1], error_sum_ff}) + (SUM_W+1)'(err_in);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         error_sum_in = {sum_wide[SUM_W], {(SUM_W-1){~sum_wide[SUM_W]}}};
      end else begin
         error_sum_in = sum_wide[SUM_W-1:0];
      end
   end

   always_comb begin
      pprod_in = $signed({1'b0, prop_gain_ff}) * err_ff;
      iprod_in = $signed({1'b0, integ_gain_ff}) * sum_ff;
   end

   // sum, clamp and floor at the switch-on threshold
   always_comb begin
      raw_sum = RAW_W'(pprod_ff) + RAW_W'(iprod_ff);
      if (raw_sum[RAW_W-1]) begin
         duty3_in = '0;
      end else if (raw_sum >= RAW_FULL) begin
         duty3_in = duty_type'(DUTY_MAX);
      end else begin
         duty3_in = raw_sum[FRAC_BITS+6:FRAC_BITS];
      end
      if (duty3_in < duty_type'(DUTY_MIN_ON)) begin
         duty3_in = '0;
      end
   end

   assign scaled_in = SCALED_W'(duty3_ff) * SCALED_W'(pwm_period_ff);
   assign qprod     = QPROD_W'(scaled_ff) * QPROD_W'(RECIP_100);

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req.valid && adv1) error_sum_ff <= error_sum_in;
         if (adv1) v1_ff <= req.valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         err_ff <= err_in;
         sum_ff <= error_sum_in;
      end
      if (adv2) begin
         pprod_ff <= pprod_in;
         iprod_ff <= iprod_in;
      end
      if (adv3) duty3_ff <= duty3_in;
      if (adv4) begin
         duty4_ff  <= duty3_ff;
         scaled_ff <= scaled_in;
      end
      if (adv5) begin
         duty_out_ff    <= duty4_ff;
         compare_out_ff <= qprod[RECIP_SHIFT+15:RECIP_SHIFT];
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.duty_percent  = duty_out_ff;
   assign rsp.compare_value = compare_out_ff;

endmodule

`default_nettype wire

[design/pihd_checker.sv]
// ---------------------------------------------------------------------------
// PI heater duty controller checker
// Port-level checks on the response channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pihd_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire pihd_pkg::duty_type    duty_percent,
   input wire pihd_pkg::compare_type compare_value
);
   import pihd_pkg::*;

   logic duty_ok;

   assign duty_ok = (duty_percent == '0) ||
                    ((duty_percent >= duty_type'(DUTY_MIN_ON)) &&
                     (duty_percent <= duty_type'(DUTY_MAX)));

   `PIHD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `PIHD_ASSERT(a_duty_range, clock, reset, rsp_valid |-> duty_ok)
   `PIHD_ASSERT(a_off_no_compare, clock, reset, rsp_valid && (duty_percent == '0) |-> compare_value == '0)
   `PIHD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind pi_heater_duty_controller_top pihd_checker u_pihd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .duty_percent  (rsp.duty_percent),
   .compare_value (rsp.compare_value)
);

`default_nettype wire
